/* rtl/core/utf8vlt_pkg.sv */
package utf8vlt_pkg;

  // Width of the internal offset counters; offsets saturate at all ones
  localparam int unsigned OFFSET_BITS = 24;
  // Width of the offset, line and column fields on the result beat
  localparam int unsigned POS_W       = 24;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [7:0]             byte_t;

  localparam offset_t OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam pos_t    LC_MAX     = {POS_W{1'b1}};
  localparam pos_t    LC_ONE     = pos_t'(1);

  // Byte classes of strict UTF-8
  localparam byte_t CONT_MASK   = 8'hC0;
  localparam byte_t CONT_TAG    = 8'h80;
  localparam byte_t ASCII_MAX   = 8'h7F;
  localparam byte_t LEAD2_MIN   = 8'hC2;
  localparam byte_t LEAD2_MAX   = 8'hDF;
  localparam byte_t LEAD3_MIN   = 8'hE0;
  localparam byte_t LEAD3_MAX   = 8'hEF;
  localparam byte_t LEAD4_MIN   = 8'hF0;
  localparam byte_t LEAD4_MAX   = 8'hF4;
  localparam byte_t LEAD_E0     = 8'hE0;
  localparam byte_t LEAD_ED     = 8'hED;
  localparam byte_t LEAD_F0     = 8'hF0;
  localparam byte_t LEAD_F4     = 8'hF4;
  localparam byte_t CONT_A0     = 8'hA0;
  localparam byte_t CONT_90     = 8'h90;
  localparam byte_t NEWLINE     = 8'h0A;

  typedef struct packed {
    byte_t data_byte;
    logic  start_text;
    logic  end_text;
  } in_beat_t;

  typedef struct packed {
    pos_t       byte_offset;
    logic       scalar_done;
    logic [2:0] scalar_length;
    pos_t       scalar_start;
    pos_t       line_number;
    pos_t       column_number;
    logic       new_line_next;
    logic       error_now;
    logic       text_invalid;
    pos_t       invalid_offset;
  } out_beat_t;

  // Map an internal offset onto the result field width
  function automatic pos_t to_pos(offset_t v);
    return POS_W'(v);
  endfunction

endpackage

/* rtl/core/utf8vlt_in_if.sv */
interface utf8vlt_in_if;
  import utf8vlt_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/utf8vlt_out_if.sv */
interface utf8vlt_out_if;
  import utf8vlt_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/utf8_validator_line_tracker.sv */
// Strict UTF-8 checker with line and column tracking. Bytes enter on in_i, one
// per beat, and every input beat yields exactly one result beat on out_o. A beat
// with start_text set clears all tracking state before its own byte is checked;
// end_text flags a sequence still open at that byte as an error. The block takes
// one byte per cycle while the result register is free: each byte lands in an
// input register, is decoded combinationally against the sequence state and
// lands in the result register. A stalled result beat blocks new bytes only
// once the input register is full. After the first error the text is marked
// invalid, the offset of the offending sequence's lead byte is held, and later
// bytes only advance the byte offset until the next start_text. Offsets, lines
// and columns saturate at all ones.
module utf8_validator_line_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  utf8vlt_in_if.sink           in_i,
  utf8vlt_out_if.source        out_o
);
  import utf8vlt_pkg::*;

  // Input register
  logic      s1_valid_q;
  in_beat_t  s1_q;
  // Result register
  logic      out_valid_q;
  out_beat_t out_q;
  out_beat_t res;

  // Sequence and position state
  logic [1:0] pending_q, pending_d;
  byte_t      lead_q, lead_d;
  logic [1:0] seen_q, seen_d;
  offset_t    origin_q, origin_d;
  offset_t    counter_q, counter_d;
  pos_t       line_q, line_d;
  pos_t       col_q, col_d;
  logic       invalid_q, invalid_d;
  offset_t    bad_q, bad_d;

  // State after an optional start-of-text clear
  logic [1:0] cur_pending;
  byte_t      cur_lead;
  logic [1:0] cur_seen;
  offset_t    cur_origin;
  offset_t    cur_counter;
  pos_t       cur_line;
  pos_t       cur_col;
  logic       cur_invalid;
  offset_t    cur_bad;

  logic  out_free;
  logic  adv;
  logic  done;
  logic  err;
  logic  ok;
  logic  nl;
  byte_t b;
  logic  last;
  logic [2:0] len;

  // Handshake: result register frees when empty or taken; input register moves on
  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign b    = s1_q.data_byte;
  assign last = s1_q.end_text;

  // Decode one byte against the sequence state
  always_comb begin
    cur_pending = pending_q;
    cur_lead    = lead_q;
    cur_seen    = seen_q;
    cur_origin  = origin_q;
    cur_counter = counter_q;
    cur_line    = line_q;
    cur_col     = col_q;
    cur_invalid = invalid_q;
    cur_bad     = bad_q;
    if (s1_q.start_text) begin
      cur_pending = '0;
      cur_lead    = '0;
      cur_seen    = '0;
      cur_origin  = '0;
      cur_counter = '0;
      cur_line    = LC_ONE;
      cur_col     = LC_ONE;
      cur_invalid = 1'b0;
      cur_bad     = '0;
    end

    pending_d = cur_pending;
    lead_d    = cur_lead;
    seen_d    = cur_seen;
    origin_d  = cur_origin;
    line_d    = cur_line;
    col_d     = cur_col;
    invalid_d = cur_invalid;
    bad_d     = cur_bad;
    done      = 1'b0;
    err       = 1'b0;
    ok        = 1'b0;
    nl        = 1'b0;
    len       = '0;
    res       = '0;

    if (!cur_invalid) begin
      if (cur_pending == 2'd0) begin
        // Lead byte: open a new sequence
        origin_d = cur_counter;
        lead_d   = b;
        seen_d   = '0;
        priority if (b <= ASCII_MAX) begin
          done = 1'b1;
          len  = 3'd1;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          pending_d = 2'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          pending_d = 2'd2;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          pending_d = 2'd3;
        end else begin
          err = 1'b1;
        end
        if (!done && !err && last) begin
          err = 1'b1;
        end
      end else begin
        // Continuation byte: check tag and the second-byte range limits
        ok = (b & CONT_MASK) == CONT_TAG;
        if (ok && cur_seen == 2'd0) begin
          if (cur_lead == LEAD_E0 && b < CONT_A0)  ok = 1'b0;
          if (cur_lead == LEAD_ED && b >= CONT_A0) ok = 1'b0;
          if (cur_lead == LEAD_F0 && b < CONT_90)  ok = 1'b0;
          if (cur_lead == LEAD_F4 && b >= CONT_90) ok = 1'b0;
        end
        if (!ok) begin
          err = 1'b1;
        end else begin
          seen_d    = cur_seen + 2'd1;
          pending_d = cur_pending - 2'd1;
          if (pending_d == 2'd0) begin
            done = 1'b1;
            len  = {1'b0, seen_d} + 3'd1;
          end else if (last) begin
            err = 1'b1;
          end
        end
      end

      if (err) begin
        // Latch the first error at the sequence's lead byte
        invalid_d = 1'b1;
        bad_d     = origin_d;
        pending_d = '0;
        seen_d    = '0;
      end else if (done) begin
        nl                = (len == 3'd1) && (b == NEWLINE);
        res.scalar_start  = to_pos(origin_d);
        res.line_number   = cur_line;
        res.column_number = cur_col;
        if (nl) begin
          line_d = (cur_line == LC_MAX) ? LC_MAX : cur_line + LC_ONE;
          col_d  = LC_ONE;
        end else begin
          col_d  = (cur_col == LC_MAX) ? LC_MAX : cur_col + LC_ONE;
        end
        seen_d = '0;
      end
    end

    counter_d = (cur_counter == OFFSET_MAX) ? OFFSET_MAX : cur_counter + offset_t'(1);

    res.byte_offset    = to_pos(cur_counter);
    res.scalar_done    = done;
    res.scalar_length  = len;
    res.new_line_next  = nl;
    res.error_now      = err;
    res.text_invalid   = invalid_d;
    res.invalid_offset = invalid_d ? to_pos(bad_d) : '0;
  end

  // Hold control state; advance on each decoded beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pending_q   <= '0;
      lead_q      <= '0;
      seen_q      <= '0;
      origin_q    <= '0;
      counter_q   <= '0;
      line_q      <= LC_ONE;
      col_q       <= LC_ONE;
      invalid_q   <= 1'b0;
      bad_q       <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (adv) begin
        pending_q <= pending_d;
        lead_q    <= lead_d;
        seen_q    <= seen_d;
        origin_q  <= origin_d;
        counter_q <= counter_d;
        line_q    <= line_d;
        col_q     <= col_d;
        invalid_q <= invalid_d;
        bad_q     <= bad_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_i.data;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  // A scalar and an error never complete on the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.scalar_done && out_q.error_now))
    else $error("scalar and error reported on one beat");

  // A completed scalar carries a length and a position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.scalar_done) |->
      (out_q.scalar_length != 3'd0 && out_q.line_number != '0 &&
       out_q.column_number != '0))
    else $error("completed scalar without length or position");

  // A reported error leaves the text invalid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.error_now) |-> out_q.text_invalid)
    else $error("error reported without sticky flag");

  // The sticky flag clears only when a start-of-text beat is decoded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(invalid_q) |-> $past(adv && s1_q.start_text))
    else $error("error flag cleared without a new text");

  // The open sequence never outlives an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    invalid_q |-> (pending_q == 2'd0))
    else $error("sequence still open after error");

endmodule
